[hw/rtl/gnt_pkg.sv]
`default_nettype none

package gnt_pkg;

  // Table geometry and number formats
  localparam int unsigned TableSize = 256;
  localparam int unsigned AddrW     = $clog2(TableSize);
  localparam int unsigned GradW     = 16;
  localparam int unsigned PermW     = 8;
  localparam int unsigned PointW    = 24;
  localparam int unsigned FracW     = 16;
  localparam int unsigned ResultW   = 18;
  localparam int unsigned OctavesDefault = 7;

  // Shared multiplier operand and product widths
  localparam int unsigned MulAW = 35;
  localparam int unsigned MulBW = 19;
  localparam int unsigned MulPW = MulAW + MulBW;

  typedef enum logic [1:0] {
    OP_LOAD_GRAD = 2'd0,
    OP_LOAD_PERM = 2'd1,
    OP_NOISE     = 2'd2,
    OP_TURB      = 2'd3
  } gnt_op_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FSQ,
    ST_FCUB,
    ST_FSTORE,
    ST_RDP,
    ST_RDG,
    ST_WXY,
    ST_WZ,
    ST_DX,
    ST_DY,
    ST_DZ,
    ST_DSUM,
    ST_TERM,
    ST_ACC,
    ST_OCT,
    ST_DONE
  } gnt_state_e;

  typedef struct packed {
    logic                    grad_we;
    logic                    perm_we;
    logic [AddrW-1:0]        idx;
    logic signed [GradW-1:0] gx;
    logic signed [GradW-1:0] gy;
    logic signed [GradW-1:0] gz;
    logic [PermW-1:0]        px;
    logic [PermW-1:0]        py;
    logic [PermW-1:0]        pz;
  } tbl_wr_t;

  typedef struct packed {
    logic             perm_re;
    logic [AddrW-1:0] ax;
    logic [AddrW-1:0] ay;
    logic [AddrW-1:0] az;
    logic             grad_re;
    logic [AddrW-1:0] ag;
  } tbl_rd_t;

  typedef struct packed {
    logic [PermW-1:0]        px;
    logic [PermW-1:0]        py;
    logic [PermW-1:0]        pz;
    logic signed [GradW-1:0] gx;
    logic signed [GradW-1:0] gy;
    logic signed [GradW-1:0] gz;
  } tbl_data_t;

endpackage

`default_nettype wire

[hw/rtl/gnt_if.sv]
`default_nettype none

interface gnt_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [7:0]  entry_index;
  logic signed [15:0] grad_x;
  logic signed [15:0] grad_y;
  logic signed [15:0] grad_z;
  logic [7:0]  perm_x_entry;
  logic [7:0]  perm_y_entry;
  logic [7:0]  perm_z_entry;
  logic [23:0] point_x;
  logic [23:0] point_y;
  logic [23:0] point_z;

  modport source (
    output valid, operation, entry_index, grad_x, grad_y, grad_z,
           perm_x_entry, perm_y_entry, perm_z_entry, point_x, point_y, point_z,
    input  ready
  );
  modport sink (
    input  valid, operation, entry_index, grad_x, grad_y, grad_z,
           perm_x_entry, perm_y_entry, perm_z_entry, point_x, point_y, point_z,
    output ready
  );
endinterface

interface gnt_out_if;
  logic               valid;
  logic               ready;
  logic signed [17:0] noise_value;
  logic               was_turbulence;

  modport source (output valid, noise_value, was_turbulence, input ready);
  modport sink (input valid, noise_value, was_turbulence, output ready);
endinterface

`default_nettype wire

[hw/rtl/gnt_tables.sv]
`default_nettype none

module gnt_tables (
  input  wire logic               clk_i,
  input  wire gnt_pkg::tbl_wr_t   wr_i,
  input  wire gnt_pkg::tbl_rd_t   rd_i,
  output gnt_pkg::tbl_data_t      data_o
);

  logic [gnt_pkg::PermW-1:0]   perm_x_mem [gnt_pkg::TableSize];
  logic [gnt_pkg::PermW-1:0]   perm_y_mem [gnt_pkg::TableSize];
  logic [gnt_pkg::PermW-1:0]   perm_z_mem [gnt_pkg::TableSize];
  logic [3*gnt_pkg::GradW-1:0] grad_mem   [gnt_pkg::TableSize];
  logic [gnt_pkg::PermW-1:0]   perm_x_rd_q, perm_y_rd_q, perm_z_rd_q;
  logic [3*gnt_pkg::GradW-1:0] grad_rd_q;

  // Write ports
  always_ff @(posedge clk_i) begin
    if (wr_i.perm_we) begin
      perm_x_mem[wr_i.idx] <= wr_i.px;
      perm_y_mem[wr_i.idx] <= wr_i.py;
      perm_z_mem[wr_i.idx] <= wr_i.pz;
    end
    if (wr_i.grad_we) begin
      grad_mem[wr_i.idx] <= {wr_i.gx, wr_i.gy, wr_i.gz};
    end
  end

  // Registered read ports, hold data when not enabled
  always_ff @(posedge clk_i) begin
    if (rd_i.perm_re) begin
      perm_x_rd_q <= perm_x_mem[rd_i.ax];
      perm_y_rd_q <= perm_y_mem[rd_i.ay];
      perm_z_rd_q <= perm_z_mem[rd_i.az];
    end
    if (rd_i.grad_re) begin
      grad_rd_q <= grad_mem[rd_i.ag];
    end
  end

  assign data_o = {perm_x_rd_q, perm_y_rd_q, perm_z_rd_q, grad_rd_q};

endmodule

`default_nettype wire

[hw/rtl/gnt_mul.sv]
`default_nettype none

module gnt_mul (
  input  wire logic                              clk_i,
  input  wire logic signed [gnt_pkg::MulAW-1:0]  a_i,
  input  wire logic signed [gnt_pkg::MulBW-1:0]  b_i,
  output logic signed      [gnt_pkg::MulPW-1:0]  p_o
);

  // Register every product
  always_ff @(posedge clk_i) begin
    p_o <= gnt_pkg::MulPW'(a_i) * gnt_pkg::MulPW'(b_i);
  end

endmodule

`default_nettype wire

[hw/rtl/gradient_noise_turbulence_unit.sv]
// 3D gradient noise and turbulence unit.
// Input channel in_i carries load and query items; output channel out_o
// carries one result per query (noise_value, was_turbulence), none per load.
// A load writes the gradient table or all three permutation tables at
// entry_index; ready stays high.
// A query runs on one shared registered multiplier under a sequencer. Each
// octave runs the fade steps for each axis, then per lattice corner two table
// reads, six products and sums, then a step that folds the octave. A
// noise query runs one octave, a turbulence query OCTAVES octaves. Ready
// is low meanwhile.
// The result waits in an output register; if the receiver stalls, the next
// query finishes its work and then holds until that register is freed.
// Reset clears the sequencer and output valid; tables are not cleared and
// must be loaded before a query reads them.
`default_nettype none

module gradient_noise_turbulence_unit #(
  parameter int unsigned OCTAVES = gnt_pkg::OctavesDefault
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  gnt_in_if.sink     in_i,
  gnt_out_if.source  out_o
);

  localparam int unsigned OctW = $clog2(OCTAVES + 1);
  localparam int unsigned AccW = 56;
  localparam int unsigned NoiseW = gnt_pkg::MulPW;
  localparam logic [17:0] KBase = 18'd196608;
  localparam logic [16:0] One   = 17'h10000;

  gnt_pkg::gnt_state_e state_q, state_d;

  logic [1:0]                 dim_q;
  logic [2:0]                 corner_q;
  logic [OctW-1:0]            oct_q;
  logic                       turb_q;
  logic [gnt_pkg::PointW-1:0] px_q, py_q, pz_q;
  logic [15:0]                fx_q, fy_q, fz_q;
  logic [16:0]                w_q;
  logic signed [34:0]         dot_q;
  logic signed [NoiseW-1:0]   noise_q;
  logic signed [AccW-1:0]     acc_q;
  logic                       out_valid_q;
  logic signed [17:0]         out_value_q;
  logic                       out_turb_q;

  gnt_pkg::tbl_wr_t   tbl_wr;
  gnt_pkg::tbl_rd_t   tbl_rd;
  gnt_pkg::tbl_data_t tbl_data;

  logic signed [gnt_pkg::MulAW-1:0] mul_a;
  logic signed [gnt_pkg::MulBW-1:0] mul_b;
  logic signed [gnt_pkg::MulPW-1:0] prod;

  logic        in_xfer, out_xfer, out_free;
  logic [15:0] tsel;
  logic [16:0] wx, wy, wz;
  logic signed [17:0] ox, oy, oz;
  logic [15:0] tx, ty, tz;
  logic signed [AccW-1:0] acc_abs;
  logic signed [23:0]     res_wide;
  logic signed [17:0]     res_sat;

  assign in_xfer  = in_i.valid && in_i.ready;
  assign out_xfer = out_o.valid && out_o.ready;
  assign out_free = !out_valid_q || out_o.ready;
  assign in_i.ready = (state_q == gnt_pkg::ST_IDLE);

  // Table write from load items
  always_comb begin
    tbl_wr.grad_we = in_xfer && (gnt_pkg::gnt_op_e'(in_i.operation) == gnt_pkg::OP_LOAD_GRAD);
    tbl_wr.perm_we = in_xfer && (gnt_pkg::gnt_op_e'(in_i.operation) == gnt_pkg::OP_LOAD_PERM);
    tbl_wr.idx = in_i.entry_index;
    tbl_wr.gx  = in_i.grad_x;
    tbl_wr.gy  = in_i.grad_y;
    tbl_wr.gz  = in_i.grad_z;
    tbl_wr.px  = in_i.perm_x_entry;
    tbl_wr.py  = in_i.perm_y_entry;
    tbl_wr.pz  = in_i.perm_z_entry;
  end

  // Corner geometry
  assign tx = px_q[gnt_pkg::FracW-1:0];
  assign ty = py_q[gnt_pkg::FracW-1:0];
  assign tz = pz_q[gnt_pkg::FracW-1:0];
  assign wx = corner_q[2] ? {1'b0, fx_q} : One - {1'b0, fx_q};
  assign wy = corner_q[1] ? {1'b0, fy_q} : One - {1'b0, fy_q};
  assign wz = corner_q[0] ? {1'b0, fz_q} : One - {1'b0, fz_q};
  assign ox = corner_q[2] ? $signed({2'b0, tx}) - $signed(18'sd65536) : $signed({2'b0, tx});
  assign oy = corner_q[1] ? $signed({2'b0, ty}) - $signed(18'sd65536) : $signed({2'b0, ty});
  assign oz = corner_q[0] ? $signed({2'b0, tz}) - $signed(18'sd65536) : $signed({2'b0, tz});

  always_comb begin
    case (dim_q)
      2'd0:    tsel = tx;
      2'd1:    tsel = ty;
      default: tsel = tz;
    endcase
  end

  // Table read addresses
  always_comb begin
    tbl_rd.perm_re = (state_q == gnt_pkg::ST_RDP);
    tbl_rd.ax = px_q[23:16] + 8'(corner_q[2]);
    tbl_rd.ay = py_q[23:16] + 8'(corner_q[1]);
    tbl_rd.az = pz_q[23:16] + 8'(corner_q[0]);
    tbl_rd.grad_re = (state_q == gnt_pkg::ST_RDG);
    tbl_rd.ag = tbl_data.px ^ tbl_data.py ^ tbl_data.pz;
  end

  // Next state and multiplier operands
  always_comb begin
    state_d = state_q;
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      gnt_pkg::ST_IDLE: begin
        if (in_xfer && in_i.operation[1]) state_d = gnt_pkg::ST_FSQ;
      end
      gnt_pkg::ST_FSQ: begin
        mul_a = $signed({19'b0, tsel});
        mul_b = $signed({3'b0, tsel});
        state_d = gnt_pkg::ST_FCUB;
      end
      gnt_pkg::ST_FCUB: begin
        mul_a = $signed({3'b0, prod[31:0]});
        mul_b = $signed({1'b0, KBase - 18'({tsel, 1'b0})});
        state_d = gnt_pkg::ST_FSTORE;
      end
      gnt_pkg::ST_FSTORE: begin
        state_d = (dim_q == 2'd2) ? gnt_pkg::ST_RDP : gnt_pkg::ST_FSQ;
      end
      gnt_pkg::ST_RDP:  state_d = gnt_pkg::ST_RDG;
      gnt_pkg::ST_RDG:  state_d = gnt_pkg::ST_WXY;
      gnt_pkg::ST_WXY: begin
        mul_a = $signed({18'b0, wx});
        mul_b = $signed({2'b0, wy});
        state_d = gnt_pkg::ST_WZ;
      end
      gnt_pkg::ST_WZ: begin
        mul_a = $signed({18'b0, prod[32:16]});
        mul_b = $signed({2'b0, wz});
        state_d = gnt_pkg::ST_DX;
      end
      gnt_pkg::ST_DX: begin
        mul_a = 35'($signed(tbl_data.gx));
        mul_b = 19'(ox);
        state_d = gnt_pkg::ST_DY;
      end
      gnt_pkg::ST_DY: begin
        mul_a = 35'($signed(tbl_data.gy));
        mul_b = 19'(oy);
        state_d = gnt_pkg::ST_DZ;
      end
      gnt_pkg::ST_DZ: begin
        mul_a = 35'($signed(tbl_data.gz));
        mul_b = 19'(oz);
        state_d = gnt_pkg::ST_DSUM;
      end
      gnt_pkg::ST_DSUM: state_d = gnt_pkg::ST_TERM;
      gnt_pkg::ST_TERM: begin
        mul_a = dot_q;
        mul_b = $signed({2'b0, w_q});
        state_d = gnt_pkg::ST_ACC;
      end
      gnt_pkg::ST_ACC: begin
        state_d = (corner_q == 3'd7) ? gnt_pkg::ST_OCT : gnt_pkg::ST_RDP;
      end
      gnt_pkg::ST_OCT: begin
        if (!turb_q || oct_q == OctW'(OCTAVES - 1)) state_d = gnt_pkg::ST_DONE;
        else state_d = gnt_pkg::ST_FSQ;
      end
      gnt_pkg::ST_DONE: begin
        if (out_free) state_d = gnt_pkg::ST_IDLE;
      end
      default: state_d = gnt_pkg::ST_IDLE;
    endcase
  end

  gnt_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  gnt_tables u_tables (
    .clk_i  (clk_i),
    .wr_i   (tbl_wr),
    .rd_i   (tbl_rd),
    .data_o (tbl_data)
  );

  // Final scaling, absolute value for turbulence, and saturation
  always_comb begin
    acc_abs  = (turb_q && acc_q[AccW-1]) ? -acc_q : acc_q;
    res_wide = acc_abs[AccW-1:32];
    if (res_wide > 24'sd131071) res_sat = 18'sd131071;
    else if (res_wide < -24'sd131072) res_sat = -18'sd131072;
    else res_sat = res_wide[17:0];
  end

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= gnt_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Sequencer counters and datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      gnt_pkg::ST_IDLE: begin
        px_q     <= in_i.point_x;
        py_q     <= in_i.point_y;
        pz_q     <= in_i.point_z;
        turb_q   <= in_i.operation[0];
        oct_q    <= '0;
        dim_q    <= '0;
        corner_q <= '0;
        acc_q    <= '0;
        noise_q  <= '0;
      end
      gnt_pkg::ST_FSTORE: begin
        case (dim_q)
          2'd0:    fx_q <= prod[47:32];
          2'd1:    fy_q <= prod[47:32];
          default: fz_q <= prod[47:32];
        endcase
        dim_q <= (dim_q == 2'd2) ? 2'd0 : dim_q + 2'd1;
      end
      gnt_pkg::ST_DX:   w_q   <= prod[32:16];
      gnt_pkg::ST_DY:   dot_q <= prod[34:0];
      gnt_pkg::ST_DZ:   dot_q <= dot_q + prod[34:0];
      gnt_pkg::ST_DSUM: dot_q <= dot_q + prod[34:0];
      gnt_pkg::ST_ACC: begin
        noise_q  <= noise_q + prod;
        corner_q <= corner_q + 3'd1;
      end
      gnt_pkg::ST_OCT: begin
        acc_q   <= acc_q + (AccW'(noise_q) >>> oct_q);
        noise_q <= '0;
        oct_q   <= oct_q + OctW'(1);
        px_q    <= {px_q[gnt_pkg::PointW-2:0], 1'b0};
        py_q    <= {py_q[gnt_pkg::PointW-2:0], 1'b0};
        pz_q    <= {pz_q[gnt_pkg::PointW-2:0], 1'b0};
      end
      default: ;
    endcase
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == gnt_pkg::ST_DONE && out_free) begin
      out_valid_q <= 1'b1;
    end else if (out_xfer) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == gnt_pkg::ST_DONE && out_free) begin
      out_value_q <= res_sat;
      out_turb_q  <= turb_q;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.noise_value    = out_value_q;
  assign out_o.was_turbulence = out_turb_q;

`ifndef SYNTHESIS
  a_query_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && in_i.operation[1] |=> state_q == gnt_pkg::ST_FSQ)
    else $error("query did not start the fade sequence");
  a_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == gnt_pkg::ST_DONE))
    else $error("result raised outside completion");
  a_corners_wrapped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == gnt_pkg::ST_OCT |-> corner_q == 3'd0)
    else $error("octave closed before all corners were summed");
`endif

endmodule

`default_nettype wire
